FILE: src/cct_pkg.sv
// Shared types, constants and helper functions for the calendar clock.
// No dependencies; imported by every module of the block.
package cct_pkg;

  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int OUT_YEAR_W = 16;
  localparam int WDAY_W  = 3;

  localparam int YEAR_WIDTH_DEF = 16;
  localparam int RESET_YEAR     = 2000;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } cct_op_t;

  localparam logic [SEC_W-1:0]   LAST_SEC  = 6'd59;
  localparam logic [MIN_W-1:0]   LAST_MIN  = 6'd59;
  localparam logic [HOUR_W-1:0]  LAST_HOUR = 5'd23;
  localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_31   = 5'd31;
  localparam logic [DAY_W-1:0]   DAYS_30   = 5'd30;
  localparam logic [DAY_W-1:0]   DAYS_29   = 5'd29;
  localparam logic [DAY_W-1:0]   DAYS_28   = 5'd28;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // 100 = 4 * 25; divisibility and quotients are split along that line
  localparam int DIV_Q      = 25;
  localparam int DIV_Q_BITS = 5;
  localparam int YEAR_BIAS  = 400;
  localparam int MOD_WEEK   = 7;
  localparam int MOD7_W     = 42;

  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic               rollover;
  } cct_time_t;

  // Inverse of DIV_Q modulo 2^64 (Newton iteration, elaboration only)
  function automatic logic [63:0] inv_div_q();
    logic [63:0] x;
    x = 64'(DIV_Q);
    for (int i = 0; i < 6; i++) begin
      x = x * (64'd2 - 64'(DIV_Q) * x);
    end
    return x;
  endfunction

  // ceil(2^(n+DIV_Q_BITS) / DIV_Q): exact quotient for n-bit dividends
  function automatic logic [63:0] recip_div_q(input int n);
    return ((64'd1 << (n + DIV_Q_BITS)) + 64'(DIV_Q - 1)) / 64'(DIV_Q);
  endfunction

  // (2*mm + 3*(mm+1)/5 + 1) mod 7, Jan/Feb counted as months 13/14
  function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [WDAY_W-1:0] r;
    case (m)
      4'd0:    r = 3'd1;
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      4'd13:   r = 3'd0;
      4'd14:   r = 3'd3;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

  // Residue mod 7 by octal digit folding (8 == 1 mod 7)
  function automatic logic [WDAY_W-1:0] mod7(input logic [MOD7_W-1:0] x);
    logic [6:0] s;
    logic [3:0] a;
    logic [3:0] b;
    s = '0;
    for (int i = 0; i < MOD7_W / 3; i++) begin
      s = s + 7'(x[3*i +: 3]);
    end
    a = 4'(s[2:0]) + 4'(s[5:3]) + 4'(s[6]);
    b = 4'(a[2:0]) + 4'(a[3]);
    if (b >= 4'(MOD_WEEK)) begin
      b = b - 4'(MOD_WEEK);
    end
    return b[2:0];
  endfunction

endpackage

FILE: src/cct_time_core.sv
// Input register and the date/time counters with carry and leap-year logic.
// Depends on cct_pkg.
module cct_time_core #(
  parameter int YEAR_WIDTH = cct_pkg::YEAR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [cct_pkg::OUT_YEAR_W-1:0] in_load_year,
  input  logic [cct_pkg::MONTH_W-1:0]   in_load_month,
  input  logic [cct_pkg::DAY_W-1:0]     in_load_day,
  input  logic [cct_pkg::HOUR_W-1:0]    in_load_hour,
  input  logic [cct_pkg::MIN_W-1:0]     in_load_minute,
  input  logic [cct_pkg::SEC_W-1:0]     in_load_second,
  output logic                          dt_valid,
  input  logic                          dt_ready,
  output cct_pkg::cct_time_t            dt_time,
  output logic [YEAR_WIDTH-1:0]         dt_year
);
  import cct_pkg::*;

  localparam logic [YEAR_WIDTH-1:0] INV_Q = YEAR_WIDTH'(inv_div_q());
  localparam logic [YEAR_WIDTH-1:0] LIM_Q =
    YEAR_WIDTH'(((64'd1 << YEAR_WIDTH) - 64'd1) / 64'(DIV_Q));

  logic                   iv_r, iv_nxt;
  logic                   op_r;
  logic [OUT_YEAR_W-1:0]  ld_year_r;
  logic [MONTH_W-1:0]     ld_month_r;
  logic [DAY_W-1:0]       ld_day_r;
  logic [HOUR_W-1:0]      ld_hour_r;
  logic [MIN_W-1:0]       ld_min_r;
  logic [SEC_W-1:0]       ld_sec_r;

  cct_time_t              time_r, time_nxt;
  logic [YEAR_WIDTH-1:0]  year_r, year_nxt;
  logic                   dv_r, dv_nxt;

  logic                   en_upd;
  logic                   take;
  logic [YEAR_WIDTH-1:0]  y_inv;
  logic                   leap;
  logic [DAY_W-1:0]       mlen;

  // state doubles as the snapshot handed downstream
  assign en_upd   = !dv_r || dt_ready;
  assign take     = iv_r && en_upd;
  assign in_ready = !iv_r || take;

  assign dt_valid = dv_r;
  assign dt_time  = time_r;
  assign dt_year  = year_r;

  // y*inv(25) mod 2^W stays at or below (2^W-1)/25 exactly when 25 | y
  assign y_inv = year_r * INV_Q;
  assign leap  = (year_r[1:0] == 2'b00) && ((y_inv > LIM_Q) || (year_r[3:0] == 4'b0000));

  always_comb begin
    case (time_r.month)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: mlen = DAYS_31;
      MON_FEB: mlen = leap ? DAYS_29 : DAYS_28;
      default: mlen = DAYS_30;
    endcase
  end

  always_comb begin
    iv_nxt = iv_r;
    if (in_ready) begin
      iv_nxt = in_valid;
    end
    dv_nxt = dv_r;
    if (en_upd) begin
      dv_nxt = iv_r;
    end
  end

  always_comb begin
    time_nxt = time_r;
    year_nxt = year_r;
    if (take) begin
      time_nxt.rollover = 1'b0;
      if (op_r == OP_LOAD) begin
        year_nxt       = YEAR_WIDTH'(ld_year_r);
        time_nxt.month = ld_month_r;
        time_nxt.day   = ld_day_r;
        time_nxt.hour  = ld_hour_r;
        time_nxt.minute = ld_min_r;
        time_nxt.second = ld_sec_r;
      end else if (time_r.second != LAST_SEC) begin
        time_nxt.second = time_r.second + 6'd1;
      end else begin
        time_nxt.second = '0;
        if (time_r.minute != LAST_MIN) begin
          time_nxt.minute = time_r.minute + 6'd1;
        end else begin
          time_nxt.minute   = '0;
          time_nxt.rollover = 1'b1;
          if (time_r.hour != LAST_HOUR) begin
            time_nxt.hour = time_r.hour + 5'd1;
          end else begin
            time_nxt.hour = '0;
            if (time_r.day != mlen) begin
              time_nxt.day = time_r.day + 5'd1;
            end else begin
              time_nxt.day = FIRST_DAY;
              if (time_r.month != MON_DEC) begin
                time_nxt.month = time_r.month + 4'd1;
              end else begin
                time_nxt.month = MON_JAN;
                year_nxt       = year_r + YEAR_WIDTH'(1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r            <= 1'b0;
      dv_r            <= 1'b0;
      time_r.second   <= '0;
      time_r.minute   <= '0;
      time_r.hour     <= '0;
      time_r.day      <= FIRST_DAY;
      time_r.month    <= MON_JAN;
      time_r.rollover <= 1'b0;
      year_r          <= YEAR_WIDTH'(RESET_YEAR);
    end else begin
      iv_r   <= iv_nxt;
      dv_r   <= dv_nxt;
      time_r <= time_nxt;
      year_r <= year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_operation;
      ld_year_r  <= in_load_year;
      ld_month_r <= in_load_month;
      ld_day_r   <= in_load_day;
      ld_hour_r  <= in_load_hour;
      ld_min_r   <= in_load_minute;
      ld_sec_r   <= in_load_second;
    end
  end

endmodule

FILE: src/cct_weekday.sv
// Weekday pipeline: year quotients, residues mod 7, and the output register.
// Depends on cct_pkg.
module cct_weekday #(
  parameter int YEAR_WIDTH = cct_pkg::YEAR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           dt_valid,
  output logic                           dt_ready,
  input  cct_pkg::cct_time_t             dt_time,
  input  logic [YEAR_WIDTH-1:0]          dt_year,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cct_pkg::SEC_W-1:0]      out_second,
  output logic [cct_pkg::MIN_W-1:0]      out_minute,
  output logic [cct_pkg::HOUR_W-1:0]     out_hour,
  output logic [cct_pkg::DAY_W-1:0]      out_day,
  output logic [cct_pkg::MONTH_W-1:0]    out_month,
  output logic [cct_pkg::OUT_YEAR_W-1:0] out_year,
  output logic [cct_pkg::WDAY_W-1:0]     out_weekday,
  output logic                           out_hour_rollover
);
  import cct_pkg::*;

  localparam int YYW = YEAR_WIDTH + 1;          // year + 400, adjusted
  localparam int QN  = YEAR_WIDTH - 1;          // width of yy / 4
  localparam int MW  = QN + 1;                  // reciprocal width
  localparam int PW  = QN + MW;                 // product width
  localparam int QW  = QN - DIV_Q_BITS + 1;     // width of yy / 100
  localparam logic [MW-1:0] RECIP = MW'(recip_div_q(QN));

  localparam int BASE_W = DAY_W + 1;

  logic                  en_a, en_b, en_out;

  // stage A
  logic                  a_valid_r, a_valid_nxt;
  cct_time_t             a_time_r;
  logic [OUT_YEAR_W-1:0] a_year_r;
  logic [YYW-1:0]        a_yy_r;
  logic [PW-1:0]         a_prod_r;
  logic                  early_month;
  logic [YYW-1:0]        yy;
  logic [QN-1:0]         a_q4;
  logic [QW-1:0]         a_q100;

  // stage B
  logic                  b_valid_r, b_valid_nxt;
  cct_time_t             b_time_r;
  logic [OUT_YEAR_W-1:0] b_year_r;
  logic [BASE_W-1:0]     b_base_r;
  logic [WDAY_W-1:0]     b_ryy_r, b_rq4_r, b_rq100_r, b_rq400_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0]     wsum;

  assign en_out   = !out_valid_r || out_ready;
  assign en_b     = !b_valid_r || en_out;
  assign en_a     = !a_valid_r || en_b;
  assign dt_ready = en_a;

  assign early_month = (dt_time.month == MON_JAN) || (dt_time.month == MON_FEB);
  assign yy = YYW'(dt_year) + YYW'(YEAR_BIAS) - YYW'(early_month);

  assign a_q4   = a_yy_r[YYW-1:2];
  assign a_q100 = a_prod_r[PW-1:QN+DIV_Q_BITS];

  // y + y/4 - y/100 + y/400 + month/day terms, all folded mod 7
  assign wsum = b_base_r + BASE_W'(b_ryy_r) + BASE_W'(b_rq4_r)
              + (BASE_W'(MOD_WEEK) - BASE_W'(b_rq100_r)) + BASE_W'(b_rq400_r);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (en_a) begin
      a_valid_nxt = dt_valid;
    end
    b_valid_nxt = b_valid_r;
    if (en_b) begin
      b_valid_nxt = a_valid_r;
    end
    out_valid_nxt = out_valid_r;
    if (en_out) begin
      out_valid_nxt = b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && dt_valid) begin
      a_time_r <= dt_time;
      a_year_r <= OUT_YEAR_W'(dt_year);
      a_yy_r   <= yy;
      a_prod_r <= PW'(yy[YYW-1:2]) * PW'(RECIP);
    end
    if (en_b && a_valid_r) begin
      b_time_r  <= a_time_r;
      b_year_r  <= a_year_r;
      b_base_r  <= BASE_W'(a_time_r.day) + BASE_W'(month_offset(a_time_r.month));
      b_ryy_r   <= mod7(MOD7_W'(a_yy_r));
      b_rq4_r   <= mod7(MOD7_W'(a_q4));
      b_rq100_r <= mod7(MOD7_W'(a_q100));
      b_rq400_r <= mod7(MOD7_W'(a_q100[QW-1:2]));
    end
    if (en_out && b_valid_r) begin
      out_second        <= b_time_r.second;
      out_minute        <= b_time_r.minute;
      out_hour          <= b_time_r.hour;
      out_day           <= b_time_r.day;
      out_month         <= b_time_r.month;
      out_year          <= b_year_r;
      out_hour_rollover <= b_time_r.rollover;
      out_weekday       <= mod7(MOD7_W'(wsum));
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/calendar_clock_tick.sv
// Calendar clock top level: counter core followed by the weekday pipeline.
// Depends on cct_pkg, cct_time_core and cct_weekday.
//
// Usage:
//   Input channel (in_valid/in_ready): in_operation selects a one-second
//   tick or a load of the full date and time from the in_load_* fields.
//   Result channel (out_valid/out_ready): every input transfer yields one
//   result with the date and time after that item, the weekday (0 Sunday)
//   and a flag set when the tick carried the minutes from 59 to 0.
//   Path: input register, counter registers, weekday stages A and B, output
//   register. Throughput: one item per cycle while out_ready is high, set
//   by the counter update (carry chain, leap-year test on the stored year).
//   The weekday is worked out in two pipelined stages behind the counters.
//   Reset (rst_n low, synchronous) empties the pipeline and sets the clock
//   to 2000-01-01 00:00:00. When the receiver stalls, results back up stage
//   by stage; in_ready drops only once every stage holds an item.
module calendar_clock_tick #(
  parameter int YEAR_WIDTH = cct_pkg::YEAR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [cct_pkg::OUT_YEAR_W-1:0] in_load_year,
  input  logic [cct_pkg::MONTH_W-1:0]    in_load_month,
  input  logic [cct_pkg::DAY_W-1:0]      in_load_day,
  input  logic [cct_pkg::HOUR_W-1:0]     in_load_hour,
  input  logic [cct_pkg::MIN_W-1:0]      in_load_minute,
  input  logic [cct_pkg::SEC_W-1:0]      in_load_second,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cct_pkg::SEC_W-1:0]      out_second,
  output logic [cct_pkg::MIN_W-1:0]      out_minute,
  output logic [cct_pkg::HOUR_W-1:0]     out_hour,
  output logic [cct_pkg::DAY_W-1:0]      out_day,
  output logic [cct_pkg::MONTH_W-1:0]    out_month,
  output logic [cct_pkg::OUT_YEAR_W-1:0] out_year,
  output logic [cct_pkg::WDAY_W-1:0]     out_weekday,
  output logic                           out_hour_rollover
);
  import cct_pkg::*;

  logic                  dt_valid;
  logic                  dt_ready;
  cct_time_t             dt_time;
  logic [YEAR_WIDTH-1:0] dt_year;

  cct_time_core #(
    .YEAR_WIDTH(YEAR_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_load_year   (in_load_year),
    .in_load_month  (in_load_month),
    .in_load_day    (in_load_day),
    .in_load_hour   (in_load_hour),
    .in_load_minute (in_load_minute),
    .in_load_second (in_load_second),
    .dt_valid       (dt_valid),
    .dt_ready       (dt_ready),
    .dt_time        (dt_time),
    .dt_year        (dt_year)
  );

  cct_weekday #(
    .YEAR_WIDTH(YEAR_WIDTH)
  ) u_weekday (
    .clk               (clk),
    .rst_n             (rst_n),
    .dt_valid          (dt_valid),
    .dt_ready          (dt_ready),
    .dt_time           (dt_time),
    .dt_year           (dt_year),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_second        (out_second),
    .out_minute        (out_minute),
    .out_hour          (out_hour),
    .out_day           (out_day),
    .out_month         (out_month),
    .out_year          (out_year),
    .out_weekday       (out_weekday),
    .out_hour_rollover (out_hour_rollover)
  );

  // backpressure reaches the input only when the whole pipeline is full
  a_full_before_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low while the pipeline has room");

  a_rollover_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hour_rollover) |-> (out_second == '0 && out_minute == '0))
    else $error("hour rollover flagged without minutes and seconds at zero");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday != 3'd7))
    else $error("weekday residue out of range");

endmodule

FILE: bench/tb.sv
// Self-checking bench for calendar_clock_tick: ticks and loads in, one time reading out.
// Depends on cct_pkg and the calendar_clock_tick RTL; keeps its own calendar model.
module tb;
  import cct_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SEC_W-1:0]      second;
    logic [MIN_W-1:0]      minute;
    logic [HOUR_W-1:0]     hour;
    logic [DAY_W-1:0]      day;
    logic [MONTH_W-1:0]    month;
    logic [OUT_YEAR_W-1:0] year;
    logic [WDAY_W-1:0]     weekday;
    logic                  rollover;
  } clock_reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [OUT_YEAR_W-1:0] in_load_year;
  logic [MONTH_W-1:0]    in_load_month;
  logic [DAY_W-1:0]      in_load_day;
  logic [HOUR_W-1:0]     in_load_hour;
  logic [MIN_W-1:0]      in_load_minute;
  logic [SEC_W-1:0]      in_load_second;
  logic                  out_valid;
  logic                  out_ready;
  logic [SEC_W-1:0]      out_second;
  logic [MIN_W-1:0]      out_minute;
  logic [HOUR_W-1:0]     out_hour;
  logic [DAY_W-1:0]      out_day;
  logic [MONTH_W-1:0]    out_month;
  logic [OUT_YEAR_W-1:0] out_year;
  logic [WDAY_W-1:0]     out_weekday;
  logic                  out_hour_rollover;

  // calendar state as the block should hold it (default 16-bit year counter)
  logic [SEC_W-1:0]      now_second;
  logic [MIN_W-1:0]      now_minute;
  logic [HOUR_W-1:0]     now_hour;
  logic [DAY_W-1:0]      now_day;
  logic [MONTH_W-1:0]    now_month;
  logic [OUT_YEAR_W-1:0] now_year;

  clock_reading_t expected_readings[$];
  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int ready_stall_pct = 0;

  calendar_clock_tick dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_load_year(in_load_year), .in_load_month(in_load_month),
    .in_load_day(in_load_day), .in_load_hour(in_load_hour),
    .in_load_minute(in_load_minute), .in_load_second(in_load_second),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_second(out_second), .out_minute(out_minute), .out_hour(out_hour),
    .out_day(out_day), .out_month(out_month), .out_year(out_year),
    .out_weekday(out_weekday), .out_hour_rollover(out_hour_rollover)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic [OUT_YEAR_W-1:0] y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: return DAYS_31;
      MON_FEB: return leap ? DAYS_29 : DAYS_28;
      default: return DAYS_30;
    endcase
  endfunction

  // Zeller-style sum; Jan/Feb belong to the previous year, +400 keeps year 0 positive
  function automatic logic [WDAY_W-1:0] weekday_of(input logic [OUT_YEAR_W-1:0] y,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic [DAY_W-1:0] d);
    longint unsigned yy;
    longint unsigned mm;
    longint unsigned sum;
    yy = y;
    yy = yy + 64'd400;
    mm = m;
    if (m == MON_JAN || m == MON_FEB) begin
      mm = mm + 64'd12;
      yy = yy - 64'd1;
    end
    sum = d + 64'd2 * mm + (64'd3 * (mm + 64'd1)) / 64'd5 + yy + yy / 64'd4
          - yy / 64'd100 + yy / 64'd400 + 64'd1;
    return WDAY_W'(sum % 64'd7);
  endfunction

  // advance the calendar by one item and queue the reading it should produce
  task automatic clock_step(input cct_op_t op,
                            input logic [OUT_YEAR_W-1:0] y, input logic [MONTH_W-1:0] mo,
                            input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h,
                            input logic [MIN_W-1:0] mi, input logic [SEC_W-1:0] s);
    clock_reading_t r;
    logic rolled;
    rolled = 1'b0;
    if (op == OP_LOAD) begin
      now_year = y;
      now_month = mo;
      now_day = d;
      now_hour = h;
      now_minute = mi;
      now_second = s;
    end else if (now_second != LAST_SEC) begin
      now_second = now_second + 6'd1;
    end else begin
      now_second = '0;
      if (now_minute != LAST_MIN) begin
        now_minute = now_minute + 6'd1;
      end else begin
        now_minute = '0;
        rolled = 1'b1;
        if (now_hour != LAST_HOUR) begin
          now_hour = now_hour + 5'd1;
        end else begin
          now_hour = '0;
          // counters only carry on an exact match, so odd loads just keep counting
          if (now_day != days_in_month(now_month, now_year)) begin
            now_day = now_day + 5'd1;
          end else begin
            now_day = FIRST_DAY;
            if (now_month != MON_DEC) begin
              now_month = now_month + 4'd1;
            end else begin
              now_month = MON_JAN;
              now_year = now_year + 16'd1;
            end
          end
        end
      end
    end
    r.second = now_second;
    r.minute = now_minute;
    r.hour = now_hour;
    r.day = now_day;
    r.month = now_month;
    r.year = now_year;
    r.weekday = weekday_of(now_year, now_month, now_day);
    r.rollover = rolled;
    expected_readings.push_back(r);
  endtask

  // caller is at a rising edge; returns at the edge of the transfer
  task automatic send_item(input cct_op_t op,
                           input logic [OUT_YEAR_W-1:0] y, input logic [MONTH_W-1:0] mo,
                           input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h,
                           input logic [MIN_W-1:0] mi, input logic [SEC_W-1:0] s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_load_year <= y;
    in_load_month <= mo;
    in_load_day <= d;
    in_load_hour <= h;
    in_load_minute <= mi;
    in_load_second <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    clock_step(op, y, mo, d, h, mi, s);
    items_sent++;
  endtask

  // load fields carry junk on a tick; the block must ignore them
  task automatic send_tick();
    send_item(OP_TICK, OUT_YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
              HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic check_reset_state();
    send_tick();
  endtask

  task automatic check_field_extremes();
    // year 0 is a leap year; January/February count as year -1 for the weekday
    send_item(OP_LOAD, 16'd0, MON_FEB, DAYS_29, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
    send_item(OP_LOAD, 16'hFFFF, MON_DEC, DAYS_31, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
  endtask

  task automatic check_leap_years();
    send_item(OP_LOAD, 16'd1900, MON_FEB, DAYS_28, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
    send_item(OP_LOAD, 16'd2000, MON_FEB, DAYS_28, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
    send_item(OP_LOAD, 16'd2024, MON_FEB, DAYS_29, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
    send_item(OP_LOAD, 16'd2023, MON_APR, DAYS_30, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
  endtask

  task automatic check_minute_hour_carry();
    send_item(OP_LOAD, 16'd2024, MON_JUL, 5'd15, 5'd10, 6'd30, LAST_SEC);
    send_tick();
    send_item(OP_LOAD, 16'd2024, MON_JUL, 5'd15, 5'd10, LAST_MIN, LAST_SEC);
    send_tick();
  endtask

  task automatic check_out_of_range_loads();
    // month 0 and 13..15 run 30 days; everything else wraps in its own width
    send_item(OP_LOAD, 16'd1999, 4'd0, DAYS_30, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
    send_item(OP_LOAD, 16'd2100, 4'd13, DAYS_30, LAST_HOUR, LAST_MIN, LAST_SEC);
    send_tick();
    send_item(OP_LOAD, 16'd4321, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_tick();
    send_item(OP_LOAD, 16'd2400, MON_MAR, 5'd0, 5'd24, 6'd60, LAST_SEC);
    send_tick();
  endtask

  // mostly loads just short of a carry followed by runs of ticks, plus junk loads
  task automatic run_random_calendar(input int n_items);
    int start_count;
    int pick;
    int n_ticks;
    logic to_december;
    logic [OUT_YEAR_W-1:0] y;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0] d;
    logic [DAY_W-1:0] mlen;
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0] mi;
    logic [SEC_W-1:0] s;
    start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        to_december = 1'b0;
        case ($urandom_range(3))
          0: y = OUT_YEAR_W'($urandom);
          1: y = OUT_YEAR_W'($urandom_range(2101, 1899));
          2: y = OUT_YEAR_W'(100 * $urandom_range(655));
          default: begin
            y = 16'hFFFF;
            to_december = 1'b1;
          end
        endcase
        mo = to_december ? MON_DEC : MONTH_W'($urandom_range(12, 1));
        mlen = days_in_month(mo, y);
        d = $urandom_range(1) ? mlen : DAY_W'($urandom_range(mlen, 1));
        h = $urandom_range(1) ? LAST_HOUR : HOUR_W'($urandom_range(23));
        mi = $urandom_range(1) ? LAST_MIN : MIN_W'($urandom_range(59));
        s = SEC_W'($urandom_range(59, 40));
        send_item(OP_LOAD, y, mo, d, h, mi, s);
        n_ticks = $urandom_range(24, 1);
      end else if (pick < 92) begin
        send_item(OP_LOAD, OUT_YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                  HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
        n_ticks = $urandom_range(8);
      end else begin
        n_ticks = 1;
      end
      repeat (n_ticks) send_tick();
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result checker: every transfer on the output is matched to the oldest reading
  always @(posedge clk) begin
    clock_reading_t got;
    clock_reading_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = {out_second, out_minute, out_hour, out_day, out_month, out_year,
             out_weekday, out_hour_rollover};
      if (expected_readings.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("tb: unexpected transfer %0d-%0d-%0d %0d:%0d:%0d wd %0d ro %0d",
                   got.year, got.month, got.day, got.hour, got.minute, got.second,
                   got.weekday, got.rollover);
        end
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (got.second !== want.second || got.minute !== want.minute ||
            got.hour !== want.hour || got.day !== want.day ||
            got.month !== want.month || got.year !== want.year ||
            got.weekday !== want.weekday || got.rollover !== want.rollover) begin
          if (mismatches < MAX_REPORTS) begin
            $display("tb: mismatch exp %0d-%0d-%0d %0d:%0d:%0d wd %0d ro %0d",
                     want.year, want.month, want.day, want.hour, want.minute,
                     want.second, want.weekday, want.rollover);
            $display("tb:          got %0d-%0d-%0d %0d:%0d:%0d wd %0d ro %0d",
                     got.year, got.month, got.day, got.hour, got.minute, got.second,
                     got.weekday, got.rollover);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_TICK;
    in_load_year <= '0;
    in_load_month <= '0;
    in_load_day <= '0;
    in_load_hour <= '0;
    in_load_minute <= '0;
    in_load_second <= '0;
    now_second = '0;
    now_minute = '0;
    now_hour = '0;
    now_day = FIRST_DAY;
    now_month = MON_JAN;
    now_year = OUT_YEAR_W'(RESET_YEAR);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 8;
    ready_stall_pct = 50;
    check_reset_state();
    check_field_extremes();
    check_leap_years();
    check_minute_hour_carry();
    check_out_of_range_loads();
    wait_all_results();
    run_random_calendar(560);
    wait_all_results();

    send_gap_pct = 50;
    ready_stall_pct = 8;
    run_random_calendar(560);
    wait_all_results();

    send_gap_pct = 0;
    ready_stall_pct = 0;
    run_random_calendar(560);
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
